// File: design/pbm_pkg.sv
// ---------------------------------------------------------------------------
// Pixel blend modes package
// Payload types, blend mode codes and the constants of the divide-by-255
// rounding that the blend pipeline shares.
// ---------------------------------------------------------------------------
package pbm_pkg;

    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 3;

    // Rounded sum before the division: 2*255*255 + 127 fits in 18 bits.
    localparam int SUM_W = 18;

    // floor(x / 255) == (x * DIV255_RECIP) >> DIV255_SHIFT for every x below
    // 132626, which covers the largest rounded sum of 130177.
    localparam int                DIV255_SHIFT = 25;
    localparam logic [SUM_W-1:0]  DIV255_RECIP = 18'd131587;
    localparam logic [SUM_W-1:0]  ROUND_BIAS   = 18'd127;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef enum logic [1:0] {
        BLEND_MULTIPLY = 2'd0,
        BLEND_SUBTRACT = 2'd1,
        BLEND_SCREEN   = 2'd2,
        BLEND_OVERLAY  = 2'd3
    } blend_mode_t;

    typedef struct packed {
        chan_t base_blue;
        chan_t base_green;
        chan_t base_red;
        chan_t top_blue;
        chan_t top_green;
        chan_t top_red;
    } pixel_pair_t;

    typedef struct packed {
        chan_t out_blue;
        chan_t out_green;
        chan_t out_red;
    } pixel_out_t;

    // Per-channel control that travels down the pipeline beside the data.
    typedef struct packed {
        logic  dbl;      // product is doubled (overlay)
        logic  inv;      // result is 255 minus the quotient
        logic  byp;      // result is the subtract value, no division
        chan_t sub;      // clamped difference for subtract
    } chan_ctrl_t;

endpackage

// File: design/pixel_blend_modes_core.sv
// ---------------------------------------------------------------------------
// Pixel blend modes core
// Blends a base BGR pixel with a top BGR pixel per channel by multiply,
// subtract, screen or overlay, with exact rounding of the division by 255.
// ---------------------------------------------------------------------------
// The core takes one pixel pair per clock and returns the blended pixel
// after its pipeline stages: operand selection, an 8 by 8 multiply, a
// reciprocal multiply that divides by 255, and the final complement or
// subtract select, each behind a register. Every stage holds its item while
// the next one cannot take it, so the core keeps one pixel per clock as long
// as the output is not stalled. blend_mode must only be written while no pixel
// is in flight.
module pixel_blend_modes_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                blend_mode_we,
    input  logic [1:0]          blend_mode_wdata,
    input  logic                pair_valid,
    output logic                pair_stall,
    input  pbm_pkg::pixel_pair_t pair,
    output logic                blend_valid,
    input  logic                blend_stall,
    output pbm_pkg::pixel_out_t blend
);
    import pbm_pkg::*;

    blend_mode_t mode_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    chan_t      base_c [NUM_CHAN];
    chan_t      top_c  [NUM_CHAN];

    chan_t      s1_a_reg    [NUM_CHAN];
    chan_t      s1_b_reg    [NUM_CHAN];
    chan_ctrl_t s1_ctrl_reg [NUM_CHAN];
    chan_t      s1_a_next   [NUM_CHAN];
    chan_t      s1_b_next   [NUM_CHAN];
    chan_ctrl_t s1_ctrl_next[NUM_CHAN];

    logic [SUM_W-1:0] s2_sum_reg  [NUM_CHAN];
    logic [SUM_W-1:0] s2_sum_next [NUM_CHAN];
    chan_ctrl_t       s2_ctrl_reg [NUM_CHAN];

    logic [CHAN_W:0]  s3_q_reg    [NUM_CHAN];
    logic [CHAN_W:0]  s3_q_next   [NUM_CHAN];
    chan_ctrl_t       s3_ctrl_reg [NUM_CHAN];

    chan_t            s4_out_reg  [NUM_CHAN];
    chan_t            s4_out_next [NUM_CHAN];

    // A stage may take a new item when it is empty or its item moves on.
    assign rdy4       = !v4_reg || !blend_stall;
    assign rdy3       = !v3_reg || rdy4;
    assign rdy2       = !v2_reg || rdy3;
    assign rdy1       = !v1_reg || rdy2;
    assign pair_stall = !rdy1;

    assign base_c[0] = pair.base_blue;
    assign base_c[1] = pair.base_green;
    assign base_c[2] = pair.base_red;
    assign top_c[0]  = pair.top_blue;
    assign top_c[1]  = pair.top_green;
    assign top_c[2]  = pair.top_red;

    // Stage 1: pick the multiplier operands. Screen and the upper overlay
    // branch work on the complements and complement the quotient again.
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            s1_a_next[c]         = base_c[c];
            s1_b_next[c]         = top_c[c];
            s1_ctrl_next[c].dbl  = 1'b0;
            s1_ctrl_next[c].inv  = 1'b0;
            s1_ctrl_next[c].byp  = 1'b0;
            s1_ctrl_next[c].sub  = (base_c[c] > top_c[c]) ? (base_c[c] - top_c[c])
                                                          : '0;
            unique case (mode_reg)
                BLEND_MULTIPLY:
                begin
                end
                BLEND_SUBTRACT:
                begin
                    s1_ctrl_next[c].byp = 1'b1;
                end
                BLEND_SCREEN:
                begin
                    s1_a_next[c]        = ~base_c[c];
                    s1_b_next[c]        = ~top_c[c];
                    s1_ctrl_next[c].inv = 1'b1;
                end
                BLEND_OVERLAY:
                begin
                    s1_ctrl_next[c].dbl = 1'b1;
                    if (top_c[c][CHAN_W-1])
                    begin
                        s1_a_next[c]        = ~base_c[c];
                        s1_b_next[c]        = ~top_c[c];
                        s1_ctrl_next[c].inv = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Stage 2: product, doubled for overlay, plus the rounding bias.
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            logic [2*CHAN_W-1:0] prod;
            prod = s1_a_reg[c] * s1_b_reg[c];
            if (s1_ctrl_reg[c].dbl)
                s2_sum_next[c] = {1'b0, prod, 1'b0} + ROUND_BIAS;
            else
                s2_sum_next[c] = {2'b00, prod} + ROUND_BIAS;
        end
    end

    // Stage 3: division by 255 through the reciprocal.
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            logic [2*SUM_W-1:0] rp;
            rp           = s2_sum_reg[c] * DIV255_RECIP;
            s3_q_next[c] = rp[DIV255_SHIFT+CHAN_W:DIV255_SHIFT];
        end
    end

    // Stage 4: select the subtract value, the quotient or its complement.
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            if (s3_ctrl_reg[c].byp)
                s4_out_next[c] = s3_ctrl_reg[c].sub;
            else if (s3_ctrl_reg[c].inv)
                s4_out_next[c] = ~s3_q_reg[c][CHAN_W-1:0];
            else
                s4_out_next[c] = s3_q_reg[c][CHAN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= BLEND_MULTIPLY;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
        end
        else
        begin
            if (blend_mode_we)
                mode_reg <= blend_mode_t'(blend_mode_wdata);
            if (rdy1)
                v1_reg <= pair_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            if (rdy1)
            begin
                s1_a_reg[c]    <= s1_a_next[c];
                s1_b_reg[c]    <= s1_b_next[c];
                s1_ctrl_reg[c] <= s1_ctrl_next[c];
            end
            if (rdy2)
            begin
                s2_sum_reg[c]  <= s2_sum_next[c];
                s2_ctrl_reg[c] <= s1_ctrl_reg[c];
            end
            if (rdy3)
            begin
                s3_q_reg[c]    <= s3_q_next[c];
                s3_ctrl_reg[c] <= s2_ctrl_reg[c];
            end
            if (rdy4)
                s4_out_reg[c]  <= s4_out_next[c];
        end
    end

    assign blend_valid     = v4_reg;
    assign blend.out_blue  = s4_out_reg[0];
    assign blend.out_green = s4_out_reg[1];
    assign blend.out_red   = s4_out_reg[2];

`ifndef NO_ASSERTIONS
    // The input can only be held off when every stage is occupied.
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        pair_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input stalled with an empty stage");

    // An accepted pixel pair always lands in the first stage.
    a_transfer_enters: assert property (
        @(posedge clk) disable iff (!rst_n)
        (pair_valid && !pair_stall) |=> v1_reg)
        else $error("accepted pixel pair lost at stage 1");

    // Every quotient of a valid item fits in one channel.
    a_quotient_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        v3_reg |-> (!s3_q_reg[0][CHAN_W] && !s3_q_reg[1][CHAN_W] &&
                    !s3_q_reg[2][CHAN_W]))
        else $error("division by 255 overflowed a channel");
`endif

endmodule
